// ===== design/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted record page package
// Field widths, stream packing widths, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

   localparam int KEY_W         = 32;
   localparam int PAYLOAD_W     = 32;
   localparam int OP_W          = 2;
   localparam int IDX_FIELD_W   = 4;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int RECORD_W      = KEY_W + PAYLOAD_W;

   localparam int REQ_FIELDS_W = OP_W + KEY_W + PAYLOAD_W + IDX_FIELD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + KEY_W + PAYLOAD_W + COUNT_FIELD_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int DEFAULT_PAGE_CAPACITY = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== design/srp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sorted_record_page.sv =====
// ----------------------------------------------------------------------------
// Sorted record page
// Holds up to PAGE_CAPACITY key/payload records in ascending signed key
// order, with insert, remove at index and read at index operations.
// ----------------------------------------------------------------------------
// One transfer is taken at a time; the block is busy until its result has
// been loaded into the output register. The records live in one RAM with a
// single write and a single registered read port, and shifting moves one
// record per cycle through that port. A rejected or unused operation goes
// straight to the response state. No clearing pass runs after reset; the
// page starts empty.
`default_nettype none

module sorted_record_page #(
   parameter int PAGE_CAPACITY = srp_pkg::DEFAULT_PAGE_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // op [1:0], new_key [33:2], new_payload [65:34], entry_index [69:66], zeros above
   input  wire logic [srp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // status [1:0], out_key [33:2], out_payload [65:34], entry_count [70:66],
   // page_full [71]
   output      logic [srp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready
);

   import srp_pkg::*;

   localparam int IDX_W = $clog2(PAGE_CAPACITY);
   localparam int CNT_W = $clog2(PAGE_CAPACITY + 1);
   localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(PAGE_CAPACITY);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_INS_STEP  = 3'd1;
   localparam logic [2:0] S_INS_PLACE = 3'd2;
   localparam logic [2:0] S_REM_STEP  = 3'd3;
   localparam logic [2:0] S_RD_WAIT   = 3'd4;
   localparam logic [2:0] S_RESP      = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [KEY_W-1:0]      new_key_ff, new_key_in;
   logic [PAYLOAD_W-1:0]  new_payload_ff, new_payload_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [KEY_W-1:0]      res_key_ff, res_key_in;
   logic [PAYLOAD_W-1:0]  res_payload_ff, res_payload_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [RECORD_W-1:0]   ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [RECORD_W-1:0]   ram_rd_data;

   logic [OP_W-1:0]        req_op;
   logic [KEY_W-1:0]       req_key;
   logic [PAYLOAD_W-1:0]   req_payload;
   logic [IDX_FIELD_W-1:0] req_index;
   logic [CMP_W-1:0]       index_ext;
   logic [CMP_W-1:0]       count_ext;
   logic [CNT_W-1:0]       pos_plus2;
   logic [KEY_W-1:0]       slot_key;

   assign req_op      = req_tdata[OP_W-1:0];
   assign req_key     = req_tdata[OP_W +: KEY_W];
   assign req_payload = req_tdata[OP_W+KEY_W +: PAYLOAD_W];
   assign req_index   = req_tdata[OP_W+KEY_W+PAYLOAD_W +: IDX_FIELD_W];
   assign index_ext   = CMP_W'(req_index);
   assign count_ext   = CMP_W'(count_ff);
   assign pos_plus2   = CNT_W'(pos_ff) + CNT_W'(2);
   assign slot_key    = ram_rd_data[RECORD_W-1 -: KEY_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   srp_ram #(
      .WIDTH (RECORD_W),
      .DEPTH (PAGE_CAPACITY)
   ) u_records (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      new_key_in     = new_key_ff;
      new_payload_in = new_payload_ff;
      res_status_in  = res_status_ff;
      res_key_in     = res_key_ff;
      res_payload_in = res_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = {new_key_ff, new_payload_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               new_key_in     = req_key;
               new_payload_in = req_payload;
               res_status_in  = ST_OK;
               res_key_in     = '0;
               res_payload_in = '0;
               state_in       = S_RESP;
               unique case (req_op)
                  OP_INSERT: begin
                     if (count_ff == CAPACITY) begin
                        res_status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {req_key, req_payload};
                        count_in    = count_ff + CNT_W'(1);
                     end else begin
                        pos_in      = IDX_W'(count_ff);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(count_ff - CNT_W'(1));
                        state_in    = S_INS_STEP;
                     end
                  end
                  OP_REMOVE: begin
                     if (index_ext >= count_ext) begin
                        res_status_in = ST_RANGE;
                     end else if (index_ext + CMP_W'(1) == count_ext) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        pos_in      = IDX_W'(req_index);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(index_ext + CMP_W'(1));
                        state_in    = S_REM_STEP;
                     end
                  end
                  OP_READ: begin
                     if (index_ext >= count_ext) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(req_index);
                        state_in    = S_RD_WAIT;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_INS_STEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            if ($signed(new_key_ff) < $signed(slot_key)) begin
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = S_INS_PLACE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = pos_ff - IDX_W'(2);
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_INS_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            count_in    = count_ff + CNT_W'(1);
            state_in    = S_RESP;
         end
         S_REM_STEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = ram_rd_data;
            pos_in      = pos_ff + IDX_W'(1);
            if (pos_plus2 == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(pos_plus2);
            end
         end
         S_RD_WAIT: begin
            res_key_in     = slot_key;
            res_payload_in = ram_rd_data[PAYLOAD_W-1:0];
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({(count_ff == CAPACITY),
                                           COUNT_FIELD_W'(count_ff),
                                           res_payload_ff, res_key_ff, res_status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      new_key_ff     <= new_key_in;
      new_payload_ff <= new_payload_in;
      res_status_ff  <= res_status_in;
      res_key_ff     <= res_key_in;
      res_payload_ff <= res_payload_in;
      rsp_data_ff    <= rsp_data_in;
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("record count exceeds page capacity");

   a_count_moves_at_finish: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (state_ff == S_RESP))
      else $error("record count changed outside the end of an operation");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_tvalid) |-> !ram_wr_en)
      else $error("record RAM written while no operation is active");

endmodule

`default_nettype wire
